/* design/sofl_pkg.sv */
package sofl_pkg;

   // Field and datapath widths
   localparam int RANGE_WIDTH    = 16;
   localparam int TIME_WIDTH     = 32;
   localparam int FORCE_WIDTH    = 32;
   localparam int SCALE_WIDTH    = 16;
   localparam int MAG_WIDTH      = 16;
   localparam int PUSH_WIDTH     = 30;
   localparam int SUM_WIDTH      = 31;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;

   localparam int NUM_SONARS = 3;

   // Direction gains in Q2.14: straight axis is 1.0, diagonal is 0.707
   localparam int AXIS_SHIFT = 14;
   localparam logic [AXIS_SHIFT-1:0] DIAG_GAIN = 14'd11583;

   // Ramp value for a range sitting on equal window bounds (1.0 in Q1.15)
   localparam logic [MAG_WIDTH-1:0] MAG_FULL = 16'd32768;

   // Register reset values
   localparam logic [RANGE_WIDTH-1:0]        MIN_DISTANCE_RESET = 16'd200;
   localparam logic [RANGE_WIDTH-1:0]        MAX_DISTANCE_RESET = 16'd2000;
   localparam logic [TIME_WIDTH-1:0]         TIMEOUT_RESET      = 32'd2000;
   localparam logic signed [SCALE_WIDTH-1:0] SCALE_RESET        = 16'sd256;

   typedef enum logic {
      OP_STORE = 1'b0,
      OP_APPLY = 1'b1
   } sofl_op_type;

   typedef enum logic [1:0] {
      SONAR_FRONT = 2'd0,
      SONAR_LEFT  = 2'd1,
      SONAR_RIGHT = 2'd2
   } sofl_sonar_type;

   typedef enum logic [2:0] {
      REG_MIN_DISTANCE = 3'd0,
      REG_MAX_DISTANCE = 3'd1,
      REG_TIMEOUT      = 3'd2,
      REG_SCALE_X      = 3'd3,
      REG_SCALE_Y      = 3'd4,
      REG_SCALE_Z      = 3'd5
   } sofl_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FORCE,
      ST_ADVANCE,
      ST_SCALE_X,
      ST_SCALE_Y,
      ST_DONE
   } sofl_state_type;

   typedef struct packed {
      logic [RANGE_WIDTH-1:0]        min_distance_mm;
      logic [RANGE_WIDTH-1:0]        max_distance_mm;
      logic [TIME_WIDTH-1:0]         timeout_ms;
      logic signed [SCALE_WIDTH-1:0] scale_x;
      logic signed [SCALE_WIDTH-1:0] scale_y;
      logic signed [SCALE_WIDTH-1:0] scale_z;
   } sofl_cfg_type;

endpackage

/* design/sofl_ifs.sv */
interface sofl_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [1:0]         sonar_index;
   logic [15:0]        range_mm;
   logic [31:0]        stamp_ms;
   logic [31:0]        now_ms;
   logic signed [31:0] wrench_x;
   logic signed [31:0] wrench_y;
   logic signed [31:0] wrench_z;

   modport source (
      output valid, op, sonar_index, range_mm, stamp_ms, now_ms,
             wrench_x, wrench_y, wrench_z,
      input  ready
   );
   modport sink (
      input  valid, op, sonar_index, range_mm, stamp_ms, now_ms,
             wrench_x, wrench_y, wrench_z,
      output ready
   );
endinterface

interface sofl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [31:0] avoid_x;
   logic signed [31:0] avoid_y;
   logic signed [31:0] avoid_z;
   logic               active;

   modport source (
      output valid, out_x, out_y, out_z, avoid_x, avoid_y, avoid_z, active,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, avoid_x, avoid_y, avoid_z, active,
      output ready
   );
endinterface

/* design/sofl_csr.sv */
module sofl_csr import sofl_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output sofl_cfg_type              cfg
);

   sofl_cfg_type cfg_ff, cfg_in;
   sofl_reg_type reg_sel;
   logic         wr_en;

   assign reg_sel = sofl_reg_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MIN_DISTANCE: cfg_in.min_distance_mm = pwdata[RANGE_WIDTH-1:0];
            REG_MAX_DISTANCE: cfg_in.max_distance_mm = pwdata[RANGE_WIDTH-1:0];
            REG_TIMEOUT:      cfg_in.timeout_ms      = pwdata[TIME_WIDTH-1:0];
            REG_SCALE_X:      cfg_in.scale_x         = $signed(pwdata[SCALE_WIDTH-1:0]);
            REG_SCALE_Y:      cfg_in.scale_y         = $signed(pwdata[SCALE_WIDTH-1:0]);
            REG_SCALE_Z:      cfg_in.scale_z         = $signed(pwdata[SCALE_WIDTH-1:0]);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MIN_DISTANCE: prdata = CSR_DATA_WIDTH'(cfg_ff.min_distance_mm);
         REG_MAX_DISTANCE: prdata = CSR_DATA_WIDTH'(cfg_ff.max_distance_mm);
         REG_TIMEOUT:      prdata = CSR_DATA_WIDTH'(cfg_ff.timeout_ms);
         REG_SCALE_X:      prdata = CSR_DATA_WIDTH'(cfg_ff.scale_x);
         REG_SCALE_Y:      prdata = CSR_DATA_WIDTH'(cfg_ff.scale_y);
         REG_SCALE_Z:      prdata = CSR_DATA_WIDTH'(cfg_ff.scale_z);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_distance_mm <= MIN_DISTANCE_RESET;
         cfg_ff.max_distance_mm <= MAX_DISTANCE_RESET;
         cfg_ff.timeout_ms      <= TIMEOUT_RESET;
         cfg_ff.scale_x         <= SCALE_RESET;
         cfg_ff.scale_y         <= SCALE_RESET;
         cfg_ff.scale_z         <= SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/sofl_div.sv */
module sofl_div import sofl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_WIDTH-1:0] dividend,
   input  logic [MAG_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [MAG_WIDTH-1:0] quotient
);

   // Divide (dividend << 15) by divisor, dividend <= divisor: one quotient
   // bit per cycle, most significant first.
   localparam int CNT_WIDTH = $clog2(MAG_WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [MAG_WIDTH:0]   rem_ff, rem_in;
   logic [MAG_WIDTH-1:0] quo_ff, quo_in;
   logic [MAG_WIDTH-1:0] div_ff, div_in;
   logic [MAG_WIDTH:0]   trial;
   logic                 fits;

   assign trial    = (cnt_ff == '0) ? rem_ff : {rem_ff[MAG_WIDTH-1:0], 1'b0};
   assign fits     = trial >= {1'b0, div_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, dividend};
         quo_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, div_ff}) : trial;
         quo_in = {quo_ff[MAG_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(MAG_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

endmodule

/* design/sofl_mul.sv */
module sofl_mul import sofl_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SUM_WIDTH-1:0]   multiplicand,
   input  logic signed [SCALE_WIDTH-1:0] multiplier,
   output logic                          done,
   output logic signed [FORCE_WIDTH-1:0] result
);

   // Shift-add over the gain bits, LSB first; the sign bit weighs negative.
   // The 48-bit product sits in {hi, lo}; result is product >> 21, rounded
   // half up.
   localparam int CNT_WIDTH = $clog2(SCALE_WIDTH);
   localparam int ACC_WIDTH = FORCE_WIDTH + 1;
   localparam int ROUND_BIT = 4;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_WIDTH-1:0]          cnt_ff, cnt_in;
   logic signed [FORCE_WIDTH-1:0] hi_ff, hi_in;
   logic [SCALE_WIDTH-1:0]        lo_ff, lo_in;
   logic signed [SUM_WIDTH-1:0]   mcand_ff, mcand_in;
   logic signed [ACC_WIDTH-1:0]   mcand_ext;
   logic signed [ACC_WIDTH-1:0]   addend;
   logic signed [ACC_WIDTH-1:0]   acc;
   logic                          last_step;

   assign last_step = cnt_ff == CNT_WIDTH'(SCALE_WIDTH - 1);
   assign mcand_ext = ACC_WIDTH'(mcand_ff);
   assign addend    = !lo_ff[0] ? '0 : (last_step ? -mcand_ext : mcand_ext);
   assign acc       = ACC_WIDTH'(hi_ff) + addend;

   assign done   = done_ff;
   assign result = FORCE_WIDTH'($signed(hi_ff[FORCE_WIDTH-1:ROUND_BIT+1]))
                 + FORCE_WIDTH'({1'b0, hi_ff[ROUND_BIT]});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         hi_in    = '0;
         lo_in    = multiplier;
         mcand_in = multiplicand;
      end else if (busy_ff) begin
         hi_in  = acc[ACC_WIDTH-1:1];
         lo_in  = {acc[0], lo_ff[SCALE_WIDTH-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

endmodule

/* design/sonar_obstacle_force_limiter.sv */
// Store beat: taken while the sequencer is idle, produces no result.
// Apply beat: each sonar is checked; a usable reading then goes through the 16-step
// serial divider (not on equal window bounds) and the force update, a skipped one
// straight to the next sonar; then come the two 16-step gain multiplies and the load.
// One apply at a time; next beat taken the cycle after the load, a held result stalls it.
// Synchronous active-high reset: sonar readings cleared, registers at defaults.
module sonar_obstacle_force_limiter import sofl_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   sofl_req_if.sink                  req_chan,
   sofl_rsp_if.source                rsp_chan,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   sofl_cfg_type cfg;

   // Sonar reading store
   logic                   seen_ff  [NUM_SONARS];
   logic [RANGE_WIDTH-1:0] range_ff [NUM_SONARS];
   logic [TIME_WIDTH-1:0]  stamp_ff [NUM_SONARS];
   logic                   store_en;
   sofl_sonar_type         store_idx;

   // Sequencer state
   sofl_state_type         state_ff, state_in;
   sofl_sonar_type         sonar_ff, sonar_in;
   logic [TIME_WIDTH-1:0]  now_ff, now_in;
   logic signed [FORCE_WIDTH-1:0] wr_x_ff, wr_x_in;
   logic signed [FORCE_WIDTH-1:0] wr_y_ff, wr_y_in;
   logic signed [FORCE_WIDTH-1:0] wr_z_ff, wr_z_in;
   logic [MAG_WIDTH-1:0]   mag_ff, mag_in;
   logic [PUSH_WIDTH-1:0]  negx_ff, negx_in;
   logic [PUSH_WIDTH-1:0]  left_y_ff, left_y_in;
   logic [PUSH_WIDTH-1:0]  right_y_ff, right_y_in;
   logic signed [FORCE_WIDTH-1:0] avoid_x_ff, avoid_x_in;
   logic signed [FORCE_WIDTH-1:0] avoid_y_ff, avoid_y_in;

   // Result register
   logic                          rsp_valid_ff;
   logic                          rsp_load;
   logic signed [FORCE_WIDTH-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic signed [FORCE_WIDTH-1:0] rsp_avoid_x_ff, rsp_avoid_y_ff;
   logic                          active_ff;

   // Datapath
   logic [TIME_WIDTH-1:0]         age;
   logic [RANGE_WIDTH-1:0]        cur_range;
   logic [RANGE_WIDTH-1:0]        span;
   logic                          reading_ok;
   logic [PUSH_WIDTH-1:0]         push_diag;
   logic [PUSH_WIDTH-1:0]         push_x;
   logic signed [SUM_WIDTH-1:0]   sum_x, sum_y;
   logic                          div_start, div_done;
   logic [MAG_WIDTH-1:0]          div_quotient;
   logic                          mul_start, mul_done;
   logic signed [SUM_WIDTH-1:0]   mul_a;
   logic signed [SCALE_WIDTH-1:0] mul_b;
   logic signed [FORCE_WIDTH-1:0] mul_result;
   logic                          hit_x, hit_y;
   logic                          req_ready;

   sofl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sofl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.max_distance_mm - cur_range),
      .divisor  (span),
      .done     (div_done),
      .quotient (div_quotient)
   );

   sofl_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_a),
      .multiplier   (mul_b),
      .done         (mul_done),
      .result       (mul_result)
   );

   // A reading counts when present, younger than the timeout (age taken
   // modulo 2^32) and inside the [min,max] window.
   assign cur_range  = range_ff[sonar_ff];
   assign age        = now_ff - stamp_ff[sonar_ff];
   assign span       = cfg.max_distance_mm - cfg.min_distance_mm;
   assign reading_ok = seen_ff[sonar_ff] && (age < cfg.timeout_ms)
                    && (cur_range >= cfg.min_distance_mm)
                    && (cur_range <= cfg.max_distance_mm);

   // Push magnitudes in Q1.29: front points straight back on x, the two
   // side sonars push at 0.707 on x and +/-0.707 on y.
   assign push_diag = PUSH_WIDTH'(mag_ff) * PUSH_WIDTH'(DIAG_GAIN);
   assign push_x    = (sonar_ff == SONAR_FRONT) ? {mag_ff, AXIS_SHIFT'(0)} : push_diag;

   // x only ever gets negative pushes: keep the strongest. y takes the
   // front-right push minus the front-left push.
   assign sum_x = SUM_WIDTH'(0) - $signed({1'b0, negx_ff});
   assign sum_y = $signed({1'b0, right_y_ff}) - $signed({1'b0, left_y_ff});

   // Clamp: an axis pushed toward the obstacle past the avoidance force
   // takes that force.
   assign hit_x = ((avoid_x_ff > 0) && (wr_x_ff < avoid_x_ff))
               || ((avoid_x_ff < 0) && (wr_x_ff > avoid_x_ff));
   assign hit_y = ((avoid_y_ff > 0) && (wr_y_ff < avoid_y_ff))
               || ((avoid_y_ff < 0) && (wr_y_ff > avoid_y_ff));

   // Store beats write straight into the reading store; index 3 is dropped.
   assign store_idx = sofl_sonar_type'(req_chan.sonar_index);
   assign store_en  = req_chan.valid && req_ready && (req_chan.op == OP_STORE)
                   && (req_chan.sonar_index < 2'(NUM_SONARS));

   assign req_chan.ready = req_ready;

   always_comb begin
      state_in   = state_ff;
      sonar_in   = sonar_ff;
      now_in     = now_ff;
      wr_x_in    = wr_x_ff;
      wr_y_in    = wr_y_ff;
      wr_z_in    = wr_z_ff;
      mag_in     = mag_ff;
      negx_in    = negx_ff;
      left_y_in  = left_y_ff;
      right_y_in = right_y_ff;
      avoid_x_in = avoid_x_ff;
      avoid_y_in = avoid_y_ff;
      req_ready  = 1'b0;
      rsp_load   = 1'b0;
      div_start  = 1'b0;
      mul_start  = 1'b0;
      mul_a      = sum_x;
      mul_b      = cfg.scale_x;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid && (req_chan.op == OP_APPLY)) begin
               now_in     = req_chan.now_ms;
               wr_x_in    = req_chan.wrench_x;
               wr_y_in    = req_chan.wrench_y;
               wr_z_in    = req_chan.wrench_z;
               negx_in    = '0;
               left_y_in  = '0;
               right_y_in = '0;
               sonar_in   = SONAR_FRONT;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!reading_ok) begin
               state_in = ST_ADVANCE;
            end else if (span == '0) begin
               mag_in   = MAG_FULL;
               state_in = ST_FORCE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mag_in   = div_quotient;
               state_in = ST_FORCE;
            end
         end
         ST_FORCE: begin
            if (push_x > negx_ff) begin
               negx_in = push_x;
            end
            if (sonar_ff == SONAR_LEFT) begin
               left_y_in = push_diag;
            end
            if (sonar_ff == SONAR_RIGHT) begin
               right_y_in = push_diag;
            end
            state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            if (sonar_ff == SONAR_RIGHT) begin
               mul_start = 1'b1;
               state_in  = ST_SCALE_X;
            end else begin
               sonar_in = sofl_sonar_type'(sonar_ff + 2'd1);
               state_in = ST_CHECK;
            end
         end
         ST_SCALE_X: begin
            mul_a = sum_y;
            mul_b = cfg.scale_y;
            if (mul_done) begin
               avoid_x_in = mul_result;
               mul_start  = 1'b1;
               state_in   = ST_SCALE_Y;
            end
         end
         ST_SCALE_Y: begin
            if (mul_done) begin
               avoid_y_in = mul_result;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the result register is free or drains this cycle.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sonar_ff <= SONAR_FRONT;
      end else begin
         state_ff <= state_in;
         sonar_ff <= sonar_in;
      end
      now_ff     <= now_in;
      wr_x_ff    <= wr_x_in;
      wr_y_ff    <= wr_y_in;
      wr_z_ff    <= wr_z_in;
      mag_ff     <= mag_in;
      negx_ff    <= negx_in;
      left_y_ff  <= left_y_in;
      right_y_ff <= right_y_in;
      avoid_x_ff <= avoid_x_in;
      avoid_y_ff <= avoid_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SONARS; i++) begin
            seen_ff[i]  <= 1'b0;
            range_ff[i] <= '0;
            stamp_ff[i] <= '0;
         end
      end else if (store_en) begin
         seen_ff[store_idx]  <= 1'b1;
         range_ff[store_idx] <= req_chan.range_mm;
         stamp_ff[store_idx] <= req_chan.stamp_ms;
      end
   end

   // Result register: load on completion, drop once the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         out_x_ff       <= hit_x ? avoid_x_ff : wr_x_ff;
         out_y_ff       <= hit_y ? avoid_y_ff : wr_y_ff;
         out_z_ff       <= wr_z_ff;
         rsp_avoid_x_ff <= avoid_x_ff;
         rsp_avoid_y_ff <= avoid_y_ff;
         active_ff      <= hit_x | hit_y;
      end
   end

   // z has no push from any sonar, so its avoidance force stays zero.
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.out_x   = out_x_ff;
   assign rsp_chan.out_y   = out_y_ff;
   assign rsp_chan.out_z   = out_z_ff;
   assign rsp_chan.avoid_x = rsp_avoid_x_ff;
   assign rsp_chan.avoid_y = rsp_avoid_y_ff;
   assign rsp_chan.avoid_z = '0;
   assign rsp_chan.active  = active_ff;

endmodule

/* tb/sonar_obstacle_force_limiter_tb.sv */
module sonar_obstacle_force_limiter_tb;
   import sofl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Sonar headings in Q2.14: front pushes straight back, the diagonals
   // push back and sideways by 0.707.
   localparam int HEADING [NUM_SONARS][3] = '{
      '{-16384,      0, 0},
      '{-11583, -11583, 0},
      '{-11583,  11583, 0}
   };

   // Register slots past the last real one; writes there must do nothing.
   localparam int REG_SPARE_LO = 6;
   localparam int REG_SPARE_HI = 7;

   // Cycles to let pass once the last result is in.
   localparam int DRAIN_CYCLES = 100;

   typedef enum {
      SINK_STREAM,
      SINK_COIN,
      SINK_SPARSE,
      SINK_STALLED
   } sink_mode_type;

   typedef struct {
      sofl_op_type        op;
      logic [1:0]         sonar_index;
      logic [15:0]        range_mm;
      logic [31:0]        stamp_ms;
      logic [31:0]        now_ms;
      logic signed [31:0] wrench_x;
      logic signed [31:0] wrench_y;
      logic signed [31:0] wrench_z;
   } sonar_beat_type;

   typedef struct {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] avoid_x;
      logic signed [31:0] avoid_y;
      logic signed [31:0] avoid_z;
      logic               active;
   } clamp_result_type;

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   sofl_req_if req_if ();
   sofl_rsp_if rsp_if ();

   sonar_obstacle_force_limiter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow copy of the limiter's registers, starting at their reset values.
   logic [15:0] win_lo   = MIN_DISTANCE_RESET;
   logic [15:0] win_hi   = MAX_DISTANCE_RESET;
   logic [31:0] stale_ms = TIMEOUT_RESET;
   int          gain [3] = '{SCALE_RESET, SCALE_RESET, SCALE_RESET};

   // Shadow copy of the latest reading per sonar.
   logic [15:0] echo_range [NUM_SONARS] = '{default: '0};
   logic [31:0] echo_stamp [NUM_SONARS] = '{default: '0};
   logic        echo_seen  [NUM_SONARS] = '{default: 1'b0};

   sonar_beat_type   beat_backlog [$];
   clamp_result_type clamped_wrench_q [$];
   sonar_beat_type   live_beat;

   int            beats_queued     = 0;
   int            beats_taken      = 0;
   int            clamp_mismatches = 0;
   int            burst_left       = 0;
   int            gap_left         = 0;
   int            stall_tick       = 0;
   sink_mode_type stall_mode       = SINK_STREAM;
   logic [31:0]   mission_ms;

   // Work out what one accepted beat does: a store updates the shadow
   // readings, an apply queues the clamped wrench it must produce.
   function automatic void predict_clamp(sonar_beat_type b);
      longint           push_hi [3];
      longint           push_lo [3];
      longint           mag;
      longint           lean;
      longint           scaled;
      int               wr [3];
      int               avoid [3];
      logic [31:0]      age;
      logic [31:0]      numer;
      logic [31:0]      span;
      clamp_result_type r;

      if (b.op == OP_STORE) begin
         // Index 3 names no sonar: drop the reading.
         if (b.sonar_index < NUM_SONARS) begin
            echo_range[b.sonar_index] = b.range_mm;
            echo_stamp[b.sonar_index] = b.stamp_ms;
            echo_seen[b.sonar_index]  = 1'b1;
         end
         return;
      end

      push_hi = '{0, 0, 0};
      push_lo = '{0, 0, 0};
      for (int s = 0; s < NUM_SONARS; s++) begin
         age = b.now_ms - echo_stamp[s];
         if (!echo_seen[s] || age >= stale_ms) continue;
         if (echo_range[s] < win_lo || echo_range[s] > win_hi) continue;
         if (win_hi == win_lo) begin
            mag = 32768;
         end else begin
            numer = {16'd0, 16'(win_hi - echo_range[s])} << 15;
            span  = {16'd0, 16'(win_hi - win_lo)};
            mag   = numer / span;
         end
         for (int ax = 0; ax < 3; ax++) begin
            lean = mag * longint'(HEADING[s][ax]);
            if (lean > 0) begin
               if (lean > push_hi[ax]) push_hi[ax] = lean;
            end else if (lean < push_lo[ax]) begin
               push_lo[ax] = lean;
            end
         end
      end

      wr = '{b.wrench_x, b.wrench_y, b.wrench_z};
      r.active = 1'b0;
      for (int ax = 0; ax < 3; ax++) begin
         // Q11.37 down to Q15.16, round half up.
         scaled    = (push_hi[ax] + push_lo[ax]) * longint'(gain[ax]);
         avoid[ax] = int'((scaled + 64'sd1048576) >>> 21);
         if ((avoid[ax] > 0 && wr[ax] < avoid[ax]) ||
             (avoid[ax] < 0 && wr[ax] > avoid[ax])) begin
            wr[ax]   = avoid[ax];
            r.active = 1'b1;
         end
      end
      r.out_x   = wr[0];
      r.out_y   = wr[1];
      r.out_z   = wr[2];
      r.avoid_x = avoid[0];
      r.avoid_y = avoid[1];
      r.avoid_z = avoid[2];
      clamped_wrench_q.insert(clamped_wrench_q.size(), r);
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         clamp_mismatches++;
         if (clamp_mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   function automatic sonar_beat_type noise_beat();
      sonar_beat_type b;
      b.op          = sofl_op_type'($urandom_range(0, 1));
      b.sonar_index = 2'($urandom_range(0, 3));
      b.range_mm    = 16'($urandom);
      b.stamp_ms    = $urandom;
      b.now_ms      = $urandom;
      b.wrench_x    = $urandom;
      b.wrench_y    = $urandom;
      b.wrench_z    = $urandom;
      return b;
   endfunction

   function automatic void enqueue(sonar_beat_type b);
      beat_backlog.insert(beat_backlog.size(), b);
      beats_queued++;
   endfunction

   // Fields that an op ignores keep random content.
   function automatic void queue_store(logic [1:0] idx, logic [15:0] range_mm,
                                       logic [31:0] stamp_ms);
      sonar_beat_type b;
      b             = noise_beat();
      b.op          = OP_STORE;
      b.sonar_index = idx;
      b.range_mm    = range_mm;
      b.stamp_ms    = stamp_ms;
      enqueue(b);
   endfunction

   function automatic void queue_apply(logic [31:0] now_ms, logic signed [31:0] wx,
                                       logic signed [31:0] wy, logic signed [31:0] wz);
      sonar_beat_type b;
      b          = noise_beat();
      b.op       = OP_APPLY;
      b.now_ms   = now_ms;
      b.wrench_x = wx;
      b.wrench_y = wy;
      b.wrench_z = wz;
      enqueue(b);
   endfunction

   // Age of a reading: mostly fresh, with the timeout edge hit often.
   function automatic logic [31:0] pick_age();
      if (stale_ms == 0) return $urandom;
      case ($urandom_range(0, 9))
         0:       return stale_ms;
         1:       return stale_ms - 1;
         2, 3:    return stale_ms + $urandom_range(0, 5000);
         default: return $urandom_range(0, stale_ms - 1);
      endcase
   endfunction

   // Range: mostly inside the window, its bounds often, anything now and then.
   function automatic logic [15:0] pick_range();
      if (win_lo > win_hi) return 16'($urandom);
      case ($urandom_range(0, 9))
         0:       return win_lo;
         1:       return win_hi;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(win_hi, win_lo));
      endcase
   endfunction

   // Wrench axis: mostly near the size of the avoidance force so that
   // both sides of the clamp get exercised.
   function automatic logic signed [31:0] pick_force();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 2))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7fff_ffff;
               default: return 32'sh0;
            endcase
         end
         2:       return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         3:       return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         default: return int'($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   // One control tick: up to three new readings, then an apply.
   function automatic void queue_scan();
      int reads;
      reads = $urandom_range(0, 3);
      repeat (reads)
         queue_store(2'($urandom_range(SONAR_FRONT, SONAR_RIGHT)), pick_range(),
                     mission_ms - pick_age());
      queue_apply(mission_ms, pick_force(), pick_force(), pick_force());
      mission_ms += $urandom_range(1, 150);
      // Jump the clock now and then so time wraps around.
      if ($urandom_range(0, 19) == 0) mission_ms += $urandom;
   endfunction

   // ---------------------------------------------------------------
   // Clock, reset and run limit
   // ---------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("sonar_obstacle_force_limiter verification failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Request driver: bursts of beats separated by random gaps
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      logic load;
      load = 1'b0;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         // Fold the beat just taken into the prediction.
         if (req_if.valid && req_if.ready) begin
            predict_clamp(live_beat);
            beats_taken++;
         end
         // Slot is free: either sit out the gap or put up the next beat.
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (beat_backlog.size() > 0) begin
               live_beat = beat_backlog.pop_front();
               load      = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // End the burst; one in four runs straight into the next.
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
               end
            end
            req_if.valid <= load;
            if (load) begin
               req_if.op          <= live_beat.op;
               req_if.sonar_index <= live_beat.sonar_index;
               req_if.range_mm    <= live_beat.range_mm;
               req_if.stamp_ms    <= live_beat.stamp_ms;
               req_if.now_ms      <= live_beat.now_ms;
               req_if.wrench_x    <= live_beat.wrench_x;
               req_if.wrench_y    <= live_beat.wrench_y;
               req_if.wrench_z    <= live_beat.wrench_z;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result sink: switch between random stall patterns that hold ready low on chosen cycles
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         stall_tick++;
         if (stall_tick % 97 == 0) stall_mode = sink_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            SINK_STREAM:  rsp_if.ready <= 1'b1;
            SINK_COIN:    rsp_if.ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE:  rsp_if.ready <= (stall_tick % 5 == 0);
            SINK_STALLED: rsp_if.ready <= (stall_tick % 40 >= 30);
            default:      rsp_if.ready <= 1'b1;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Result monitor: compare every beat with the oldest prediction
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      clamp_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (clamped_wrench_q.size() == 0) begin
            clamp_mismatches++;
            if (clamp_mismatches <= 10)
               $display("result beat with nothing pending: out %h %h %h avoid %h %h %h act %b",
                        rsp_if.out_x, rsp_if.out_y, rsp_if.out_z, rsp_if.avoid_x,
                        rsp_if.avoid_y, rsp_if.avoid_z, rsp_if.active);
         end else begin
            want = clamped_wrench_q.pop_front();
            check_field("out_x", want.out_x, rsp_if.out_x);
            check_field("out_y", want.out_y, rsp_if.out_y);
            check_field("out_z", want.out_z, rsp_if.out_z);
            check_field("avoid_x", want.avoid_x, rsp_if.avoid_x);
            check_field("avoid_y", want.avoid_y, rsp_if.avoid_y);
            check_field("avoid_z", want.avoid_z, rsp_if.avoid_z);
            check_field("active", 32'(want.active), 32'(rsp_if.active));
         end
      end
   end

   // ---------------------------------------------------------------
   // Register access and phase control
   // ---------------------------------------------------------------

   // Setup cycle, then access cycle; the write lands on the access edge.
   task automatic csr_write(int idx, logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WIDTH'(idx * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_MIN_DISTANCE: win_lo   = value[15:0];
         REG_MAX_DISTANCE: win_hi   = value[15:0];
         REG_TIMEOUT:      stale_ms = value;
         REG_SCALE_X:      gain[0]  = $signed(value[15:0]);
         REG_SCALE_Y:      gain[1]  = $signed(value[15:0]);
         REG_SCALE_Z:      gain[2]  = $signed(value[15:0]);
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic tune_limits(logic [15:0] lo, logic [15:0] hi, logic [31:0] stale,
                              logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
      csr_write(REG_MIN_DISTANCE, {16'd0, lo});
      csr_write(REG_MAX_DISTANCE, {16'd0, hi});
      csr_write(REG_TIMEOUT, stale);
      csr_write(REG_SCALE_X, {16'd0, gx});
      csr_write(REG_SCALE_Y, {16'd0, gy});
      csr_write(REG_SCALE_Z, {16'd0, gz});
   endtask

   // Hold until every queued beat is taken and every result is back,
   // then let a store or apply still in flight finish.
   task automatic settle();
      do @(negedge clock);
      while (beats_taken != beats_queued || clamped_wrench_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly control ticks; one pick in five is a single pure-noise beat.
   task automatic run_phase(int n);
      int start;
      start = beats_queued;
      while (beats_queued - start < n) begin
         if ($urandom_range(0, 4) == 0) enqueue(noise_beat());
         else queue_scan();
      end
      settle();
   endtask

   initial begin
      logic [15:0] lo;

      // Drive every input to a known value before the first edge.
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_if.valid       = 1'b0;
      req_if.op          = OP_STORE;
      req_if.sonar_index = '0;
      req_if.range_mm    = '0;
      req_if.stamp_ms    = '0;
      req_if.now_ms      = '0;
      req_if.wrench_x    = '0;
      req_if.wrench_y    = '0;
      req_if.wrench_z    = '0;
      rsp_if.ready       = 1'b0;
      mission_ms         = $urandom;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Defaults: window 200..2000, timeout 2000, unit gains.
      // No reading yet: the wrench passes, even at its extremes.
      queue_apply(32'd0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh0);
      // Front at the near bound gives the full push; left at the far bound
      // gives none; right has a stamp just before time wraps.
      queue_store(SONAR_FRONT, 16'd200, 32'd1000);
      queue_store(SONAR_LEFT, 16'd2000, 32'd1000);
      queue_store(SONAR_RIGHT, 16'd1100, 32'hffff_ff00);
      // No sonar sits at index 3: the store must vanish.
      queue_store(2'd3, 16'd500, 32'd1000);
      queue_apply(32'd1500, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
      // One ms short of the timeout, then exactly at it.
      queue_apply(32'd2999, 32'sh0, 32'sh0, 32'sh0);
      queue_apply(32'd3000, -32'sd5, 32'sd5, 32'sh0);
      // Just outside the window on both sides, and the widest range.
      queue_store(SONAR_FRONT, 16'd199, 32'd3000);
      queue_store(SONAR_LEFT, 16'd2001, 32'd3000);
      queue_store(SONAR_RIGHT, 16'hffff, 32'd3000);
      queue_apply(32'd3001, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
      // Zero range with the largest stamp, and two readings just inside.
      queue_store(SONAR_FRONT, 16'd0, 32'hffff_ffff);
      queue_store(SONAR_RIGHT, 16'd1999, 32'd3000);
      queue_store(SONAR_LEFT, 16'd201, 32'd3000);
      queue_apply(32'd3010, 32'sh4000_0000, 32'shc000_0000, 32'sd1);
      queue_store(SONAR_FRONT, 16'd1000, 32'd3010);
      queue_apply(32'd3010, 32'sh0, 32'sh0, 32'sh7fff_ffff);
      queue_apply(32'hffff_ffff, pick_force(), pick_force(), pick_force());
      run_phase(220);

      // Zero timeout: every reading is stale.
      tune_limits(16'd100, 16'd3000, 32'd0, 16'sd256, 16'sd256, 16'sd256);
      queue_store(SONAR_FRONT, 16'd500, mission_ms);
      queue_apply(mission_ms, 32'sh0, 32'sh0, 32'sh0);
      run_phase(60);

      // Minimum above maximum: nothing lies in the window.
      tune_limits(16'd5000, 16'd1000, 32'd4000, 16'sd256, 16'sd256, 16'sd256);
      queue_store(SONAR_FRONT, 16'd3000, mission_ms);
      queue_store(SONAR_LEFT, 16'd500, mission_ms);
      queue_apply(mission_ms, 32'sh0, 32'sh0, 32'sh0);
      run_phase(60);

      // Equal bounds: a range right on them takes the full push.
      tune_limits(16'd777, 16'd777, 32'hffff_ffff, 16'sd256, -16'sd256, 16'sd256);
      queue_store(SONAR_FRONT, 16'd777, mission_ms);
      queue_store(SONAR_LEFT, 16'd777, mission_ms);
      queue_store(SONAR_RIGHT, 16'd777, mission_ms);
      queue_apply(mission_ms, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0);
      run_phase(100);

      // Widest window, longest timeout, extreme gains; poke the spare slots.
      tune_limits(16'd0, 16'hffff, 32'hffff_ffff, 16'sh7fff, 16'sh8000, 16'sh0);
      csr_write(REG_SPARE_LO, 32'hffff_ffff);
      csr_write(REG_SPARE_HI, 32'h0000_0001);
      run_phase(200);

      // Narrowest window, one-ms timeout, small gains of both signs.
      tune_limits(16'd0, 16'd1, 32'd1, -16'sd1, 16'sd1, -16'sd256);
      run_phase(100);

      // Random settings.
      repeat (4) begin
         lo = 16'($urandom_range(0, 3000));
         tune_limits(lo, lo + 16'($urandom_range(1, 5000)),
                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(50, 3000),
                     16'($urandom), 16'($urandom), 16'($urandom));
         run_phase(180);
      end

      settle();
      if (clamp_mismatches == 0 && clamped_wrench_q.size() == 0) begin
         $display("sonar_obstacle_force_limiter verification clean");
      end else begin
         $display("sonar_obstacle_force_limiter verification failed");
      end
      $finish;
   end

endmodule
